@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL files.
// Each check runs on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define DCV_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define DCV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/dcv_pkg.sv @@
package dcv_pkg;

    // 96-bit mantissa held as three 32-bit limbs, limb 2 most significant
    localparam int LIMB_W = 32;
    localparam int LIMBS  = 3;

    // ceil(2^38 / 10); exact floor(x / 10) for every x below 10 * 2^32
    localparam logic [34:0] DIV10_RECIP = 35'h666666667;

    // Magnitude limits of the signed 32-bit result
    localparam logic [63:0] POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] NEG_LIMIT = 64'h0000_0000_8000_0000;

    typedef struct packed {
        logic [63:0] mantissa_low;
        logic [31:0] mantissa_high;
        logic [7:0]  scale;
        logic        negative;
    } dcv_in_t;

    typedef struct packed {
        logic signed [31:0] int_value;
        logic               status;
    } dcv_out_t;

endpackage

@@ hw/rtl/decimal_to_int_convert_top.sv @@
// A request is taken only while the core is idle; it then runs k division steps, where k is the lesser of
// scale and the number of divisions by ten that bring the mantissa to zero (k <= 29).
// Each division step walks the shared divide-by-ten unit over three 32-bit limbs.
// No new request is accepted until the result has entered the output slot; a full slot stalls the core.
// Reset clears the sequencer and the output valid; payload registers are not reset.
module decimal_to_int_convert_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dcv_pkg::dcv_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output dcv_pkg::dcv_out_t out_data
);
    import dcv_pkg::*;

    logic     res_ready;
    logic     res_valid;
    dcv_out_t res_data;

    logic     out_valid_reg, out_valid_next;
    dcv_out_t out_data_reg;

    dcv_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    // Output slot is free when empty or being drained this cycle
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ hw/rtl/dcv_div10.sv @@
module dcv_div10 (
    input  logic [3:0]  rem_in,
    input  logic [31:0] limb_in,
    output logic [31:0] quo,
    output logic [3:0]  rem_out
);
    import dcv_pkg::*;

    // Bit position of the quotient in the reciprocal product
    localparam int Q_LSB = 38;

    logic [35:0] cur;
    logic [70:0] prod;
    logic [3:0]  q_times_ten;

    // Form the partial dividend: carried remainder above the current limb
    assign cur  = {rem_in, limb_in};

    // Multiply by the reciprocal of ten and keep the integer part
    assign prod = {35'd0, cur} * {36'd0, DIV10_RECIP};
    assign quo  = prod[Q_LSB + LIMB_W - 1:Q_LSB];

    // Recover the remainder from the low bits only: it is below ten
    assign q_times_ten = {quo[2:0], 1'b0} + {quo[0], 3'b000};
    assign rem_out     = cur[3:0] - q_times_ten;

endmodule

@@ hw/rtl/dcv_core.sv @@
`include "assert_macros.svh"

module dcv_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  dcv_pkg::dcv_in_t  in_data,
    input  logic            res_ready,
    output logic            res_valid,
    output dcv_pkg::dcv_out_t res_data
);
    import dcv_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_STEP   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam logic [1:0] LIMB_TOP  = 2'd2;
    localparam logic [1:0] LIMB_LOW  = 2'd0;

    logic [1:0]                   state_reg, state_next;
    logic [1:0]                   limb_reg, limb_next;
    logic [3:0]                   rem_reg, rem_next;
    logic [7:0]                   steps_reg, steps_next;
    logic                         neg_reg, neg_next;
    logic [LIMBS-1:0][LIMB_W-1:0] w_reg, w_next;

    logic [3:0]  div_rem_in;
    logic [31:0] div_limb_in;
    logic [31:0] div_quo;
    logic [3:0]  div_rem_out;

    logic [63:0] mag;
    logic [63:0] limit;
    logic        ovf;

    // Shared divide-by-ten unit, one limb per cycle
    assign div_rem_in  = (limb_reg == LIMB_TOP) ? 4'd0 : rem_reg;
    assign div_limb_in = w_reg[limb_reg];

    dcv_div10 u_div10 (
        .rem_in  (div_rem_in),
        .limb_in (div_limb_in),
        .quo     (div_quo),
        .rem_out (div_rem_out)
    );

    // Range check and sign application on the truncated magnitude
    assign mag   = {w_reg[1], w_reg[0]};
    assign limit = neg_reg ? NEG_LIMIT : POS_LIMIT;
    assign ovf   = (w_reg[2] != '0) || (mag > limit);

    always_comb
    begin
        res_data.status    = ovf;
        if (ovf)
        begin
            res_data.int_value = '0;
        end
        else if (neg_reg)
        begin
            res_data.int_value = 32'sd0 - $signed(w_reg[0]);
        end
        else
        begin
            res_data.int_value = $signed(w_reg[0]);
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_FINISH) && res_ready;

    // Sequencer: load, divide limb by limb, finish
    always_comb
    begin
        state_next = state_reg;
        limb_next  = limb_reg;
        rem_next   = rem_reg;
        steps_next = steps_reg;
        neg_next   = neg_reg;
        w_next     = w_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    w_next[0]  = in_data.mantissa_low[31:0];
                    w_next[1]  = in_data.mantissa_low[63:32];
                    w_next[2]  = in_data.mantissa_high;
                    steps_next = in_data.scale;
                    neg_next   = in_data.negative;
                    limb_next  = LIMB_TOP;
                    rem_next   = 4'd0;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if ((limb_reg == LIMB_TOP) && ((steps_reg == 8'd0) || (w_reg == '0)))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    w_next[limb_reg] = div_quo;
                    rem_next         = div_rem_out;
                    if (limb_reg == LIMB_LOW)
                    begin
                        limb_next  = LIMB_TOP;
                        steps_next = steps_reg - 8'd1;
                    end
                    else
                    begin
                        limb_next = limb_reg - 2'd1;
                    end
                end
            end
            ST_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            limb_reg  <= LIMB_TOP;
        end
        else
        begin
            state_reg <= state_next;
            limb_reg  <= limb_next;
        end
    end

    // Working value, no reset needed
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        steps_reg <= steps_next;
        neg_reg   <= neg_next;
        w_reg     <= w_next;
    end

    `DCV_ASSERT_IMP(a_res_slot_free, res_valid, res_ready,
        "result issued while output slot is full")
    `DCV_ASSERT_NEXT(a_mid_step_holds, (state_reg == ST_STEP) && (limb_reg != LIMB_TOP),
        state_reg == ST_STEP, "division step left before its last limb")
    `DCV_ASSERT_IMP(a_ovf_zero, res_valid && res_data.status, res_data.int_value == 32'sd0,
        "overflow result carries a nonzero value")

endmodule

@@ sim/decimal_to_int_convert_top_test.sv @@
`timescale 1ns / 1ps

module decimal_to_int_convert_top_test;

    import dcv_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_WAIT  = 120;
    localparam int REPORT_MAX   = 10;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    dcv_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    dcv_out_t out_data;

    dcv_in_t  pending_decimals[$];
    dcv_out_t expected_ints[$];

    int       sender_idle_pct;
    int       sink_stall_pct;
    logic     req_taken;
    int       mismatch_count;
    int       cycle_count;

    decimal_to_int_convert_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Divide by ten once per scale step, then range-check and apply the sign
    function automatic dcv_out_t truncate_to_int(dcv_in_t req);
        logic [95:0] mag;
        int          steps;
        dcv_out_t    res;
        mag   = {req.mantissa_high, req.mantissa_low};
        steps = int'(req.scale);
        while (steps > 0 && mag != '0)
        begin
            mag = mag / 96'd10;
            steps--;
        end
        res = '0;
        if (mag > (req.negative ? {32'd0, NEG_LIMIT} : {32'd0, POS_LIMIT}))
        begin
            res.status = 1'b1;
        end
        else
        begin
            res.int_value = req.negative ? (32'd0 - mag[31:0]) : mag[31:0];
        end
        return res;
    endfunction

    function automatic logic [95:0] random_96();
        return {$urandom, $urandom, $urandom};
    endfunction

    function automatic logic [95:0] power_of_ten(int exp10);
        logic [95:0] p;
        p = 96'd1;
        repeat (exp10) p = p * 96'd10;
        return p;
    endfunction

    // Mix wide random values, values near the int32 edge, 32-bit values and tiny magnitudes
    function automatic dcv_in_t random_decimal();
        dcv_in_t     req;
        logic [95:0] mag;
        logic [95:0] p;
        int          pick;
        int          s;
        pick = $urandom_range(9);
        req.negative = 1'($urandom_range(1));
        if (pick <= 2)
        begin
            mag = random_96();
            if ($urandom_range(9) < 7)
                req.scale = 8'($urandom_range(30));
            else
                req.scale = 8'($urandom_range(255));
        end
        else if (pick <= 6)
        begin
            s   = $urandom_range(19);
            p   = power_of_ten(s);
            mag = (96'd2147483645 + 96'($urandom_range(6))) * p + (random_96() % p);
            req.scale = 8'(s);
        end
        else if (pick <= 8)
        begin
            mag = {64'd0, $urandom};
            req.scale = 8'($urandom_range(12));
        end
        else
        begin
            mag = 96'($urandom_range(9));
            req.scale = 8'($urandom_range(255));
        end
        req.mantissa_high = mag[95:64];
        req.mantissa_low  = mag[63:0];
        return req;
    endfunction

    task automatic push_decimal(input logic [31:0] hi, input logic [63:0] lo,
                                input logic [7:0] scl, input logic neg);
        dcv_in_t req;
        req.mantissa_high = hi;
        req.mantissa_low  = lo;
        req.scale         = scl;
        req.negative      = neg;
        pending_decimals.push_back(req);
    endtask

    // Hold until every queued request went out and every result came back
    task automatic drain_requests();
        while (pending_decimals.size() != 0 || in_valid || expected_ints.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        repeat (count) pending_decimals.push_back(random_decimal());
        drain_requests();
    endtask

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Drive requests and output stalls on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || req_taken)
            begin
                if (pending_decimals.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    in_data  <= pending_decimals.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Record accepted requests and check results on the rising edge
    always @(posedge clk)
    begin
        dcv_out_t want;
        if (rst_n)
        begin
            req_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
                expected_ints.push_back(truncate_to_int(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_ints.size() == 0)
                begin
                    if (mismatch_count < REPORT_MAX)
                        $display("unexpected result: int_value %0d status %0b",
                                 out_data.int_value, out_data.status);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_ints.pop_front();
                    if (out_data.int_value !== want.int_value ||
                        out_data.status !== want.status)
                    begin
                        if (mismatch_count < REPORT_MAX)
                            $display("mismatch: int_value exp %0d got %0d, status exp %0b got %0b",
                                     want.int_value, out_data.int_value,
                                     want.status, out_data.status);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_data         = '0;
        out_ready       = 1'b0;
        req_taken       = 1'b0;
        mismatch_count  = 0;
        cycle_count     = 0;
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Edges of the fields, sign limits, negative zero and oversize scales
        push_decimal(32'd0, 64'd0, 8'd0, 1'b0);
        push_decimal(32'd0, 64'd0, 8'd255, 1'b1);
        push_decimal('1, '1, 8'd0, 1'b0);
        push_decimal('1, '1, 8'd28, 1'b1);
        push_decimal('1, '1, 8'd29, 1'b0);
        push_decimal('1, '1, 8'd255, 1'b1);
        push_decimal(32'd0, 64'd2147483647, 8'd0, 1'b0);
        push_decimal(32'd0, 64'd2147483648, 8'd0, 1'b0);
        push_decimal(32'd0, 64'd2147483648, 8'd0, 1'b1);
        push_decimal(32'd0, 64'd2147483649, 8'd0, 1'b1);
        push_decimal(32'd0, 64'd21474836479, 8'd1, 1'b0);
        push_decimal(32'd0, 64'd21474836480, 8'd1, 1'b0);
        push_decimal(32'd0, 64'd21474836480, 8'd1, 1'b1);
        push_decimal(32'd0, 64'd21474836490, 8'd1, 1'b1);
        push_decimal(32'd1, 64'd0, 8'd0, 1'b0);
        push_decimal(32'd1, 64'd0, 8'd10, 1'b1);
        push_decimal(32'd0, '1, 8'd10, 1'b0);
        push_decimal(32'd0, 64'd123456789, 8'd3, 1'b1);
        push_decimal(32'd0, 64'd9, 8'd1, 1'b0);
        push_decimal(32'd0, 64'd10, 8'd1, 1'b1);
        push_decimal(32'd0, 64'd5, 8'd200, 1'b1);
        push_decimal(32'hAAAA_AAAA, 64'h5555_5555_5555_5555, 8'd17, 1'b0);
        push_decimal(32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 8'd18, 1'b1);

        run_phase(0, 0, 265);
        run_phase(47, 0, 260);
        run_phase(0, 47, 260);
        run_phase(37, 37, 265);

        repeat (SETTLE_WAIT) @(posedge clk);
        if (mismatch_count == 0 && expected_ints.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
